[hw/rtl/vtac_pkg.sv]
// Shared types, codes and helpers for the VLAN tagging-by-address-class block.
package vtac_pkg;

    localparam int NUM_COUNTERS = 8;
    localparam int COUNTER_BITS_DEF = 64;
    localparam int CIDX_W = $clog2(NUM_COUNTERS);
    localparam int VID_W = 12;
    localparam int CVAL_W = 64;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REQ_ETHER  = 2'd0;
    localparam logic [1:0] REQ_BRIDGE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] V_DROP   = 2'd0;
    localparam logic [1:0] V_BRIDGE = 2'd1;
    localparam logic [1:0] V_ETHER  = 2'd2;
    localparam logic [1:0] V_UNUSED = 2'd3;

    localparam logic [2:0] R_NONE      = 3'd0;
    localparam logic [2:0] R_BAD_FRAME = 3'd1;
    localparam logic [2:0] R_RSVD_VID  = 3'd2;
    localparam logic [2:0] R_FOREIGN   = 3'd3;
    localparam logic [2:0] R_BAD_IP6   = 3'd4;
    localparam logic [2:0] R_UNK_ETH   = 3'd5;

    localparam logic [CIDX_W-1:0] EV_BADFRAME = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] EV_INLINE   = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] EV_DROPVID  = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] EV_FOREIGN  = CIDX_W'(3);
    localparam logic [CIDX_W-1:0] EV_TAG4     = CIDX_W'(4);
    localparam logic [CIDX_W-1:0] EV_TAGULA   = CIDX_W'(5);
    localparam logic [CIDX_W-1:0] EV_BAD6     = CIDX_W'(6);
    localparam logic [CIDX_W-1:0] EV_UNKETH   = CIDX_W'(7);

    localparam logic [15:0] ETH_VLAN = 16'h8100;
    localparam logic [15:0] ETH_IP4  = 16'h0800;
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IP6  = 16'h86DD;
    localparam logic [VID_W-1:0] VID_RESERVED = 12'hFFF;

    localparam logic REG_ULA_VID = 1'b0;
    localparam logic REG_IP4_VID = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        frame_ok;
        logic [15:0] outer_ethertype;
        logic [15:0] vlan_tci;
        logic [15:0] inner_ethertype;
        logic        oob_tag_present;
        logic [15:0] oob_tag;
        logic [7:0]  dst_octet0;
        logic [7:0]  dst_octet1;
        logic [2:0]  counter_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        verdict;
        logic              tag_present;
        logic [VID_W-1:0]  vlan_id;
        logic [2:0]        drop_reason;
        logic [CVAL_W-1:0] counter_value;
        logic              last;
    } out_word_t;

    typedef struct packed {
        out_word_t         res0;
        out_word_t         res1;
        logic              two;
        logic              read;
        logic              clear;
        logic              bump;
        logic [CIDX_W-1:0] bump_idx;
        logic              inline_bump;
        logic [CIDX_W-1:0] rd_idx;
    } cls_t;

    typedef struct packed {
        logic              commit;
        logic              clear;
        logic              bump;
        logic [CIDX_W-1:0] idx;
        logic              inline_bump;
    } cnt_upd_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'b01,
        PH_SECOND = 2'b10
    } phase_t;

    function automatic out_word_t mk_res(input logic [1:0] verdict,
                                         input logic [VID_W-1:0] vid,
                                         input logic [2:0] reason,
                                         input logic last);
        out_word_t r;
        r.verdict       = verdict;
        r.tag_present   = (vid != '0);
        r.vlan_id       = vid;
        r.drop_reason   = reason;
        r.counter_value = '0;
        r.last          = last;
        return r;
    endfunction

endpackage

[hw/rtl/vtac_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vtac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/vtac_classify.sv]
// Header classification: tag strip, verdict, drop reason and counter event.
module vtac_classify import vtac_pkg::*; (
    input  in_word_t         item,
    input  logic [VID_W-1:0] ula_vid,
    input  logic [VID_W-1:0] ip4_vid,
    output cls_t             cls
);

    logic             inline_tag;
    logic [15:0]      etype;
    logic [VID_W-1:0] vid;
    logic             ip6_global;
    logic             ip6_mcast_ll;
    logic             ip6_ula;

    always_comb
    begin
        inline_tag = (item.outer_ethertype == ETH_VLAN);
        etype      = inline_tag ? item.inner_ethertype : item.outer_ethertype;
        if (inline_tag)
        begin
            vid = item.vlan_tci[VID_W-1:0];
        end
        else if (item.oob_tag_present)
        begin
            vid = item.oob_tag[VID_W-1:0];
        end
        else
        begin
            vid = '0;
        end

        ip6_global   = ((item.dst_octet0 & 8'hE0) == 8'h20);
        ip6_mcast_ll = (item.dst_octet0 == 8'hFF) ||
                       ((item.dst_octet0 == 8'hFE) && ((item.dst_octet1 & 8'hC0) == 8'h80));
        ip6_ula      = (item.dst_octet0 != 8'hFE) && ((item.dst_octet0 & 8'hFC) == 8'hFC);

        cls          = '0;
        cls.res0     = mk_res(V_DROP, '0, R_NONE, 1'b1);
        cls.res1     = mk_res(V_BRIDGE, ula_vid, R_NONE, 1'b1);

        case (item.req_type)
            REQ_READ:
            begin
                cls.read = 1'b1;
            end
            REQ_CLEAR:
            begin
                cls.clear = 1'b1;
            end
            default:
            begin
                if (!item.frame_ok)
                begin
                    cls.bump     = 1'b1;
                    cls.bump_idx = EV_BADFRAME;
                    cls.res0     = mk_res(V_DROP, '0, R_BAD_FRAME, 1'b1);
                end
                else
                begin
                    cls.inline_bump = inline_tag;
                    if (item.req_type == REQ_BRIDGE)
                    begin
                        if (vid == VID_RESERVED)
                        begin
                            cls.bump     = 1'b1;
                            cls.bump_idx = EV_DROPVID;
                            cls.res0     = mk_res(V_DROP, '0, R_RSVD_VID, 1'b1);
                        end
                        else if (vid != '0 && vid != ula_vid && vid != ip4_vid)
                        begin
                            cls.bump     = 1'b1;
                            cls.bump_idx = EV_FOREIGN;
                            cls.res0     = mk_res(V_DROP, '0, R_FOREIGN, 1'b1);
                        end
                        else
                        begin
                            cls.res0 = mk_res(V_ETHER, '0, R_NONE, 1'b1);
                        end
                    end
                    else if (etype inside {ETH_IP4, ETH_ARP})
                    begin
                        if (ip4_vid == VID_RESERVED)
                        begin
                            cls.bump     = 1'b1;
                            cls.bump_idx = EV_DROPVID;
                            cls.res0     = mk_res(V_DROP, '0, R_RSVD_VID, 1'b1);
                        end
                        else
                        begin
                            cls.bump     = (ip4_vid != '0);
                            cls.bump_idx = EV_TAG4;
                            cls.res0     = mk_res(V_BRIDGE, ip4_vid, R_NONE, 1'b1);
                        end
                    end
                    else if (etype == ETH_IP6)
                    begin
                        if (ip6_global)
                        begin
                            cls.res0 = mk_res(V_BRIDGE, '0, R_NONE, 1'b1);
                        end
                        else if (ip6_mcast_ll)
                        begin
                            cls.two      = (ula_vid != '0);
                            cls.bump     = (ula_vid != '0);
                            cls.bump_idx = EV_TAGULA;
                            cls.res0     = mk_res(V_BRIDGE, '0, R_NONE, ula_vid == '0);
                        end
                        else if (ip6_ula)
                        begin
                            cls.bump     = (ula_vid != '0);
                            cls.bump_idx = EV_TAGULA;
                            cls.res0     = mk_res(V_BRIDGE, ula_vid, R_NONE, 1'b1);
                        end
                        else
                        begin
                            cls.bump     = 1'b1;
                            cls.bump_idx = EV_BAD6;
                            cls.res0     = mk_res(V_DROP, '0, R_BAD_IP6, 1'b1);
                        end
                    end
                    else
                    begin
                        cls.bump     = 1'b1;
                        cls.bump_idx = EV_UNKETH;
                        cls.res0     = mk_res(V_DROP, '0, R_UNK_ETH, 1'b1);
                    end
                end
            end
        endcase

        cls.rd_idx = cls.read ? item.counter_index : cls.bump_idx;
    end

endmodule

[hw/rtl/vtac_counters.sv]
// Event counter store: counter RAM with valid bits, write forwarding, tag counter.
module vtac_counters import vtac_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rd_en,
    input  logic [CIDX_W-1:0]       rd_addr,
    input  cnt_upd_t                upd,
    output logic [COUNTER_BITS-1:0] cur_val,
    output logic [COUNTER_BITS-1:0] inline_val
);

    logic [NUM_COUNTERS-1:0] vld_reg, vld_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic                    fwd_hit_reg, fwd_hit_next;
    logic [COUNTER_BITS-1:0] fwd_val_reg, fwd_val_next;
    logic [COUNTER_BITS-1:0] inl_reg, inl_next;
    logic [COUNTER_BITS-1:0] rd_data;
    logic [COUNTER_BITS-1:0] inc_val;
    logic                    we;

    vtac_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (NUM_COUNTERS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (upd.idx),
        .wdata (inc_val),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        cur_val    = fwd_hit_reg ? fwd_val_reg : (rd_vld_reg ? rd_data : '0);
        inc_val    = cur_val + COUNTER_BITS'(1);
        inline_val = inl_reg;
        we         = upd.commit && upd.bump;

        vld_next = vld_reg;
        inl_next = inl_reg;
        if (upd.commit && upd.clear)
        begin
            vld_next = '0;
            inl_next = '0;
        end
        else
        begin
            if (we)
            begin
                vld_next[upd.idx] = 1'b1;
            end
            if (upd.commit && upd.inline_bump)
            begin
                inl_next = inl_reg + COUNTER_BITS'(1);
            end
        end

        rd_vld_next  = rd_vld_reg;
        fwd_hit_next = fwd_hit_reg;
        fwd_val_next = fwd_val_reg;
        if (rd_en)
        begin
            rd_vld_next  = vld_reg[rd_addr];
            fwd_hit_next = upd.commit && (upd.clear || (upd.bump && upd.idx == rd_addr));
            fwd_val_next = upd.clear ? '0 : inc_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
            inl_reg     <= '0;
        end
        else
        begin
            vld_reg     <= vld_next;
            rd_vld_reg  <= rd_vld_next;
            fwd_hit_reg <= fwd_hit_next;
            inl_reg     <= inl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_val_reg <= fwd_val_next;
    end

endmodule

[hw/rtl/vlan_tag_by_address_class_top.sv]
// Top level: config registers, classify stage, counter stage and output register.
// Takes one header summary or counter request per cycle while item_stall is low. A
// result word passes through the stage-1 register and then the output register, and
// is taken when result_stall is low; an IPv6 multicast or link-local frame with a
// nonzero ULA VID gives two words, untagged then tagged, and stalls the input until
// the second word leaves stage 1. Event counters sit in an 8-entry RAM, except the
// in-line tag counter, which is a register of its own. The RAM is read as the item is
// accepted and written back when the item's first word enters the output register,
// with bypass when the next item hits the same counter; clearing resets every counter
// at once. The output register lets a new item in while one word waits on result_stall.
module vlan_tag_by_address_class_top import vtac_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  in_word_t           item,
    output logic               result_valid,
    input  logic               result_stall,
    output out_word_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [VID_W-1:0] ula_vid_reg, ula_vid_next;
    logic [VID_W-1:0] ip4_vid_reg, ip4_vid_next;
    logic             cfg_wr;

    cls_t             cls;
    logic             s1_vld_reg, s1_vld_next;
    phase_t           s1_ph_reg, s1_ph_next;
    cls_t             s1_cls_reg;
    logic             out_vld_reg, out_vld_next;
    out_word_t        out_reg;
    out_word_t        s1_word;

    logic             accept, out_take, s1_fire, s1_final;
    cnt_upd_t         upd;
    logic [COUNTER_BITS-1:0] cur_val, inline_val, read_val;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        ula_vid_next = ula_vid_reg;
        ip4_vid_next = ip4_vid_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_ULA_VID: ula_vid_next = pwdata[VID_W-1:0];
                REG_IP4_VID: ip4_vid_next = pwdata[VID_W-1:0];
                default: ;
            endcase
        end
        case (paddr[2])
            REG_ULA_VID: prdata = PDATA_W'(ula_vid_reg);
            REG_IP4_VID: prdata = PDATA_W'(ip4_vid_reg);
            default:     prdata = '0;
        endcase
    end

    vtac_classify u_classify (
        .item    (item),
        .ula_vid (ula_vid_reg),
        .ip4_vid (ip4_vid_reg),
        .cls     (cls)
    );

    always_comb
    begin
        out_take   = !out_vld_reg || !result_stall;
        s1_fire    = s1_vld_reg && out_take;
        s1_final   = s1_fire && (!s1_cls_reg.two || s1_ph_reg == PH_SECOND);
        item_stall = s1_vld_reg && !s1_final;
        accept     = item_valid && !item_stall;

        upd.commit      = s1_fire && s1_ph_reg == PH_FIRST;
        upd.clear       = s1_cls_reg.clear;
        upd.bump        = s1_cls_reg.bump;
        upd.idx         = s1_cls_reg.bump_idx;
        upd.inline_bump = s1_cls_reg.inline_bump;

        read_val = (s1_cls_reg.rd_idx == EV_INLINE) ? inline_val : cur_val;
        if (s1_ph_reg == PH_SECOND)
        begin
            s1_word = s1_cls_reg.res1;
        end
        else
        begin
            s1_word = s1_cls_reg.res0;
            if (s1_cls_reg.read)
            begin
                s1_word.counter_value = CVAL_W'(read_val);
            end
        end

        s1_vld_next = s1_vld_reg;
        s1_ph_next  = s1_ph_reg;
        if (accept)
        begin
            s1_vld_next = 1'b1;
            s1_ph_next  = PH_FIRST;
        end
        else if (s1_final)
        begin
            s1_vld_next = 1'b0;
            s1_ph_next  = PH_FIRST;
        end
        else if (s1_fire)
        begin
            s1_ph_next = PH_SECOND;
        end

        out_vld_next = out_take ? s1_vld_reg : out_vld_reg;
    end

    vtac_counters #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_counters (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (cls.rd_idx),
        .upd        (upd),
        .cur_val    (cur_val),
        .inline_val (inline_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ula_vid_reg <= '0;
            ip4_vid_reg <= '0;
            s1_vld_reg  <= 1'b0;
            s1_ph_reg   <= PH_FIRST;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            ula_vid_reg <= ula_vid_next;
            ip4_vid_reg <= ip4_vid_next;
            s1_vld_reg  <= s1_vld_next;
            s1_ph_reg   <= s1_ph_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cls_reg <= cls;
        end
        if (out_take && s1_vld_reg)
        begin
            out_reg <= s1_word;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

[hw/rtl/vtac_checker.sv]
// Port-level checks on the result channel, bound to the top level.
module vtac_checker import vtac_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_stall,
    input out_word_t result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last |=>
            result_valid && result.last && result.tag_present &&
            result.verdict == V_BRIDGE)
        else $error("untagged copy not followed by tagged copy");

    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.verdict != V_UNUSED &&
            result.tag_present == (result.vlan_id != '0))
        else $error("bad verdict or tag flag");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.drop_reason != R_NONE |->
            result.verdict == V_DROP && !result.tag_present && result.last &&
            result.counter_value == '0)
        else $error("malformed drop word");

    a_cval: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.verdict != V_DROP |-> result.counter_value == '0)
        else $error("counter value on a forwarded frame");

endmodule

bind vlan_tag_by_address_class_top vtac_checker u_checker (.*);
